>>> hdl/eha_pkg.sv
// Package for the energy histogram accumulator.
// Holds sizes, register and mode codes, the sequencer state type and shared structs.
// No dependencies.
`default_nettype none

package eha_pkg;

  localparam int NUM_CHANNELS  = 4;
  localparam int BIN_ADDR_BITS = 16;

  localparam int ENERGY_BITS = 16;
  localparam int EVENT_CH    = 4;
  localparam int CH_BITS     = $clog2(EVENT_CH);
  localparam int USED_CH     = (NUM_CHANNELS < EVENT_CH) ? NUM_CHANNELS : EVENT_CH;
  localparam logic [EVENT_CH-1:0] USED_MASK = EVENT_CH'((1 << USED_CH) - 1);

  localparam int BIN_BITS   = 32;
  localparam int TOTAL_BITS = 48;
  localparam int SHIFT_BITS = 5;
  localparam int CFG_BITS   = 5;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [BIN_BITS-1:0]   BIN_MAX   = '1;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic [SHIFT_BITS-1:0] SHIFT_LIMIT = SHIFT_BITS'(ENERGY_BITS);

  localparam logic [CFG_IDX_BITS-1:0] CFG_CHANNEL_ENABLE = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENERGY_SHIFT   = 1'b1;

  localparam logic MODE_HIT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIT,
    ST_READ,
    ST_RDATA,
    ST_RESULT
  } seq_state_t;

  typedef struct packed {
    logic [EVENT_CH-1:0]   channel_enable;
    logic [SHIFT_BITS-1:0] energy_shift;
  } cfg_t;

  typedef struct packed {
    logic                                  mode;
    logic [EVENT_CH-1:0][ENERGY_BITS-1:0]  energy;
    logic [EVENT_CH-1:0]                   hit_mask;
    logic [ENERGY_BITS-1:0]                read_bin;
  } event_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]    bin_count;
    logic [TOTAL_BITS-1:0]  total_count;
    logic [ENERGY_BITS-1:0] highest_bin;
  } result_t;

  typedef struct packed {
    logic                     we;
    logic [BIN_ADDR_BITS-1:0] waddr;
    logic [BIN_BITS-1:0]      wdata;
    logic [BIN_ADDR_BITS-1:0] raddr;
  } ram_req_t;

  function automatic logic [SHIFT_BITS-1:0] eff_shift(input logic [SHIFT_BITS-1:0] shift);
    eff_shift = (shift > SHIFT_LIMIT) ? SHIFT_LIMIT : shift;
  endfunction

endpackage

`default_nettype wire

>>> hdl/eha_bin_ram.sv
// Single-clock bin memory: one write port, one read port, registered read data.
// Generic; no package dependency.
`default_nettype none

module eha_bin_ram #(
  parameter int ADDR_BITS = 16,
  parameter int DATA_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [DATA_BITS-1:0] wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [(1 << ADDR_BITS)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/eha_seq.sv
// Sequencer for the histogram: clearing sweep, per-channel read-modify-write, bin reads.
// Depends on eha_pkg; drives the bin memory through eha_pkg::ram_req_t.
`default_nettype none

module eha_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire eha_pkg::cfg_t      cfg,
  input  wire logic               ev_valid,
  output logic                    ev_stall,
  input  wire eha_pkg::event_t    ev,
  output eha_pkg::ram_req_t       ram_req,
  input  wire logic [eha_pkg::BIN_BITS-1:0] ram_rdata,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output eha_pkg::result_t        res
);

  eha_pkg::seq_state_t state;
  eha_pkg::seq_state_t state_next;

  logic [eha_pkg::BIN_ADDR_BITS-1:0] clr_addr;
  logic [eha_pkg::EVENT_CH-1:0][eha_pkg::ENERGY_BITS-1:0] energy;
  logic [eha_pkg::EVENT_CH-1:0] pend;
  logic [eha_pkg::ENERGY_BITS-1:0] rd_idx;
  logic [eha_pkg::BIN_BITS-1:0] bin_count;

  logic                              w_valid;
  logic [eha_pkg::BIN_ADDR_BITS-1:0] w_addr;
  logic                              fwd_valid;
  logic [eha_pkg::BIN_ADDR_BITS-1:0] fwd_addr;
  logic [eha_pkg::BIN_BITS-1:0]      fwd_data;

  logic [eha_pkg::TOTAL_BITS-1:0]  total;
  logic [eha_pkg::ENERGY_BITS-1:0] highest;

  logic                              accept;
  logic                              issue;
  logic                              clearing;
  logic                              clr_last;
  logic [eha_pkg::CH_BITS-1:0]       sel_ch;
  logic [eha_pkg::SHIFT_BITS-1:0]    shift;
  logic [eha_pkg::BIN_ADDR_BITS-1:0] sel_bin;
  logic [eha_pkg::BIN_BITS-1:0]      cur_count;
  logic [eha_pkg::BIN_BITS-1:0]      new_count;
  logic                              in_range;

  assign shift    = eha_pkg::eff_shift(cfg.energy_shift);
  assign clr_last = (clr_addr == '1);

  always_comb begin
    sel_ch = '0;
    for (int i = eha_pkg::EVENT_CH - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel_ch = eha_pkg::CH_BITS'(i);
      end
    end
  end

  assign sel_bin = eha_pkg::BIN_ADDR_BITS'(energy[sel_ch] >> shift);

  assign cur_count = (fwd_valid && (fwd_addr == w_addr)) ? fwd_data : ram_rdata;
  assign new_count = (cur_count == eha_pkg::BIN_MAX) ? cur_count
                                                      : cur_count + eha_pkg::BIN_BITS'(1);

  assign in_range = ((17'(rd_idx) >> (eha_pkg::SHIFT_BITS'(eha_pkg::ENERGY_BITS) - shift)) == '0)
                    && ((32'(rd_idx) >> eha_pkg::BIN_ADDR_BITS) == '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      eha_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_next = eha_pkg::ST_IDLE;
        end
      end
      eha_pkg::ST_IDLE: begin
        if (ev_valid) begin
          state_next = (ev.mode == eha_pkg::MODE_READ) ? eha_pkg::ST_READ : eha_pkg::ST_HIT;
        end
      end
      eha_pkg::ST_HIT: begin
        if (pend == '0) begin
          state_next = eha_pkg::ST_RESULT;
        end
      end
      eha_pkg::ST_READ:  state_next = eha_pkg::ST_RDATA;
      eha_pkg::ST_RDATA: state_next = eha_pkg::ST_RESULT;
      eha_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_next = eha_pkg::ST_IDLE;
        end
      end
      default: state_next = eha_pkg::ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    ev_stall  = 1'b1;
    res_valid = 1'b0;
    issue     = 1'b0;
    clearing  = 1'b0;
    case (state)
      eha_pkg::ST_CLEAR:  clearing  = 1'b1;
      eha_pkg::ST_IDLE:   ev_stall  = 1'b0;
      eha_pkg::ST_HIT:    issue     = (pend != '0);
      eha_pkg::ST_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign accept = ev_valid && !ev_stall;

  always_comb begin
    ram_req.we    = w_valid;
    ram_req.waddr = w_addr;
    ram_req.wdata = new_count;
    ram_req.raddr = (state == eha_pkg::ST_READ) ? eha_pkg::BIN_ADDR_BITS'(rd_idx) : sel_bin;
    if (clearing) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_addr;
      ram_req.wdata = '0;
    end
  end

  always_comb begin
    res.bin_count   = bin_count;
    res.total_count = total;
    res.highest_bin = highest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= eha_pkg::ST_CLEAR;
      clr_addr  <= '0;
      pend      <= '0;
      w_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      total     <= '0;
      highest   <= '0;
    end else begin
      state     <= state_next;
      w_valid   <= issue;
      fwd_valid <= w_valid;
      if (clearing) begin
        clr_addr <= clr_addr + eha_pkg::BIN_ADDR_BITS'(1);
      end
      if (accept) begin
        pend <= (ev.mode == eha_pkg::MODE_HIT)
                ? (ev.hit_mask & cfg.channel_enable & eha_pkg::USED_MASK) : '0;
      end else if (issue) begin
        pend[sel_ch] <= 1'b0;
      end
      if (w_valid) begin
        if (total != eha_pkg::TOTAL_MAX) begin
          total <= total + eha_pkg::TOTAL_BITS'(1);
        end
        if (eha_pkg::ENERGY_BITS'(w_addr) > highest) begin
          highest <= eha_pkg::ENERGY_BITS'(w_addr);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      energy    <= ev.energy;
      rd_idx    <= ev.read_bin;
      bin_count <= '0;
    end
    if (state == eha_pkg::ST_RDATA) begin
      bin_count <= in_range ? ram_rdata : '0;
    end
    if (issue) begin
      w_addr <= sel_bin;
    end
    if (w_valid) begin
      fwd_addr <= w_addr;
      fwd_data <= new_count;
    end
  end

endmodule

`default_nettype wire

>>> hdl/energy_histogram_accumulator_top.sv
// Top level of the energy histogram accumulator: config registers, output register.
// Depends on eha_pkg, eha_bin_ram and eha_seq.
//
//  channel  | direction | handshake          | words
//  ---------+-----------+--------------------+-----------------------------------------
//  in       | sink      | in_valid/in_stall  | mode, energy_ch0..3, hit_mask, read_bin
//  out      | source    | out_valid/out_stall| bin_count, total_count, highest_bin
//  cfg      | sink      | cfg_write          | cfg_index, cfg_data
//
// A hit word updates one bin for each enabled hit channel; a read word reads one bin.
// Each bin update is a read-modify-write through the bin memory's read and write ports,
// pipelined with one-back forwarding.
// After reset a clearing sweep writes all 65536 bins with in_stall high.
// One word is in flight at a time; a result waits in the output register while the
// next word is accepted.
`default_nettype none

module energy_histogram_accumulator_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   mode,
  input  wire logic [eha_pkg::ENERGY_BITS-1:0]        energy_ch0,
  input  wire logic [eha_pkg::ENERGY_BITS-1:0]        energy_ch1,
  input  wire logic [eha_pkg::ENERGY_BITS-1:0]        energy_ch2,
  input  wire logic [eha_pkg::ENERGY_BITS-1:0]        energy_ch3,
  input  wire logic [eha_pkg::EVENT_CH-1:0]           hit_mask,
  input  wire logic [eha_pkg::ENERGY_BITS-1:0]        read_bin,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic      [eha_pkg::BIN_BITS-1:0]           bin_count,
  output logic      [eha_pkg::TOTAL_BITS-1:0]         total_count,
  output logic      [eha_pkg::ENERGY_BITS-1:0]        highest_bin,
  input  wire logic                                   cfg_write,
  input  wire logic [eha_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [eha_pkg::CFG_BITS-1:0]           cfg_data
);

  eha_pkg::cfg_t     cfg;
  eha_pkg::event_t   ev;
  eha_pkg::ram_req_t ram_req;
  eha_pkg::result_t  res;
  logic [eha_pkg::BIN_BITS-1:0] ram_rdata;
  logic res_valid;
  logic res_ready;

  always_comb begin
    ev.mode      = mode;
    ev.energy[0] = energy_ch0;
    ev.energy[1] = energy_ch1;
    ev.energy[2] = energy_ch2;
    ev.energy[3] = energy_ch3;
    ev.hit_mask  = hit_mask;
    ev.read_bin  = read_bin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_enable <= eha_pkg::EVENT_CH'(1);
      cfg.energy_shift   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        eha_pkg::CFG_CHANNEL_ENABLE: cfg.channel_enable <= eha_pkg::EVENT_CH'(cfg_data);
        eha_pkg::CFG_ENERGY_SHIFT:   cfg.energy_shift   <= eha_pkg::SHIFT_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  eha_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ev_valid  (in_valid),
    .ev_stall  (in_stall),
    .ev        (ev),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  eha_bin_ram #(
    .ADDR_BITS (eha_pkg::BIN_ADDR_BITS),
    .DATA_BITS (eha_pkg::BIN_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      bin_count   <= res.bin_count;
      total_count <= res.total_count;
      highest_bin <= res.highest_bin;
    end
  end

endmodule

`default_nettype wire
